// ----- sv/bis_pkg.sv -----
// bis_pkg: shared constants, codes and the command type of the bilinear image sampler
// no dependencies; imported by every module of the block

package bis_pkg;

  localparam int MaxCols     = 256;
  localparam int MaxRows     = 256;
  localparam int FracBits    = 8;
  localparam int MaxChannels = 3;

  // fixed field widths of the stream and configuration ports
  localparam int PixW     = 8;
  localparam int CoordW   = 17;
  localparam int ChanW    = 2;
  localparam int SampleW  = 24;
  localparam int InDataW  = 64;
  localparam int OutUserW = 3;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 9;

  // input tdata field offsets, lowest field first
  localparam int RowLo   = 0;
  localparam int ColLo   = RowLo + PixW;
  localparam int ChanLo  = ColLo + PixW;
  localparam int ValueLo = ChanLo + ChanW;
  localparam int XLo     = ValueLo + PixW;
  localparam int YLo     = XLo + CoordW;

  localparam int RowW = $clog2(MaxRows);
  localparam int ColW = $clog2(MaxCols);
  localparam int IntW = CoordW - 1 - FracBits;

  localparam int One  = 1 << FracBits;
  localparam int WtW  = FracBits + 1;
  localparam int TvW  = FracBits + PixW;
  localparam int ValW = 2 * FracBits + PixW;

  // image memory split in four banks by row and column parity
  localparam int NumBanks  = 4;
  localparam int BankRows  = (MaxRows + 1) / 2;
  localparam int BankCols  = (MaxCols + 1) / 2;
  localparam int BankDepth = BankRows * BankCols * MaxChannels;
  localparam int AddrW     = $clog2(BankDepth);

  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);

  typedef enum logic {
    KindWrite = 1'b0,
    KindQuery = 1'b1
  } bis_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgWidth    = 2'd0,
    CfgHeight   = 2'd1,
    CfgChannels = 2'd2
  } bis_cfg_e;

  // chan holds the channel of a write, or the last channel index of a query
  typedef struct packed {
    bis_kind_e            kind;
    logic                 in_img;
    logic [RowW-1:0]      row;
    logic [ColW-1:0]      col;
    logic [ChanW-1:0]     chan;
    logic [PixW-1:0]      value;
    logic [FracBits-1:0]  fx;
    logic [FracBits-1:0]  fy;
  } bis_cmd_t;

endpackage

// ----- sv/bis_front.sv -----
// bis_front: input stream acceptance, configuration registers and request decode
// depends on bis_pkg; feeds decoded commands to bis_fifo

module bis_front import bis_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // pix_row, pix_col, pix_chan, pix_value, x_coord, y_coord, zero fill
  input  logic [InDataW-1:0]  s_axis_tdata,
  // kind
  input  logic [0:0]          s_axis_tuser,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                full_i,
  output logic                push_o,
  output bis_cmd_t            push_cmd_o
);

  logic [CfgDataW-1:0] width_q, height_q;
  logic [ChanW-1:0]    chans_q;

  logic [CoordW-1:0]   x, y;
  logic [IntW-1:0]     x_int, y_int;
  logic [FracBits-1:0] fx, fy;
  logic [IntW:0]       x_hi, y_hi;
  logic [CfgDataW-1:0] w_eff, h_eff;
  logic [ChanW-1:0]    nch;
  logic [PixW-1:0]     pix_row, pix_col, pix_value;
  logic [ChanW-1:0]    pix_chan;
  logic                in_img, wr_ok;
  bis_kind_e           kind;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgDataW'(256);
      height_q <= CfgDataW'(256);
      chans_q  <= ChanW'(1);
    end else if (cfg_valid_i) begin
      unique case (bis_cfg_e'(cfg_index_i))
        CfgWidth:    width_q  <= cfg_data_i;
        CfgHeight:   height_q <= cfg_data_i;
        CfgChannels: chans_q  <= cfg_data_i[ChanW-1:0];
        default: ;
      endcase
    end
  end

  assign kind      = bis_kind_e'(s_axis_tuser[0]);
  assign pix_row   = s_axis_tdata[RowLo +: PixW];
  assign pix_col   = s_axis_tdata[ColLo +: PixW];
  assign pix_chan  = s_axis_tdata[ChanLo +: ChanW];
  assign pix_value = s_axis_tdata[ValueLo +: PixW];
  assign x         = s_axis_tdata[XLo +: CoordW];
  assign y         = s_axis_tdata[YLo +: CoordW];

  assign x_int = x[CoordW-2:FracBits];
  assign y_int = y[CoordW-2:FracBits];
  assign fx    = x[FracBits-1:0];
  assign fy    = y[FracBits-1:0];
  assign x_hi  = {1'b0, x_int} + {{IntW{1'b0}}, |fx};
  assign y_hi  = {1'b0, y_int} + {{IntW{1'b0}}, |fy};

  always_comb begin
    w_eff = (32'(width_q) > MaxCols) ? CfgDataW'(MaxCols) : width_q;
    h_eff = (32'(height_q) > MaxRows) ? CfgDataW'(MaxRows) : height_q;
    if (chans_q == '0) begin
      nch = ChanW'(1);
    end else if (32'(chans_q) > MaxChannels) begin
      nch = ChanW'(MaxChannels);
    end else begin
      nch = chans_q;
    end
  end

  // right and bottom neighbours are never left of or above the anchor
  assign in_img = !x[CoordW-1] && !y[CoordW-1] &&
                  (32'(x_hi) < 32'(w_eff)) && (32'(y_hi) < 32'(h_eff));

  assign wr_ok = (32'(pix_row) < MaxRows) && (32'(pix_col) < MaxCols) &&
                 (32'(pix_chan) < MaxChannels);

  assign s_axis_tready = !full_i;
  assign push_o = s_axis_tvalid && !full_i && ((kind == KindQuery) || wr_ok);

  always_comb begin
    push_cmd_o.kind = kind;
    if (kind == KindQuery) begin
      push_cmd_o.in_img = in_img;
      push_cmd_o.row    = RowW'(y_int);
      push_cmd_o.col    = ColW'(x_int);
      push_cmd_o.chan   = nch - ChanW'(1);
      push_cmd_o.value  = '0;
      push_cmd_o.fx     = fx;
      push_cmd_o.fy     = fy;
    end else begin
      push_cmd_o.in_img = 1'b0;
      push_cmd_o.row    = RowW'(pix_row);
      push_cmd_o.col    = ColW'(pix_col);
      push_cmd_o.chan   = pix_chan;
      push_cmd_o.value  = pix_value;
      push_cmd_o.fx     = '0;
      push_cmd_o.fy     = '0;
    end
  end

endmodule

// ----- sv/bis_fifo.sv -----
// bis_fifo: short command queue between the front and the back end
// depends on bis_pkg for the command type and queue depth

module bis_fifo import bis_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  bis_cmd_t push_cmd_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     pop_valid_o,
  output bis_cmd_t pop_cmd_o
);

  bis_cmd_t         entries_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   count_q;

  assign full_o      = count_q == (QPtrW+1)'(QueueDepth);
  assign pop_valid_o = count_q != '0;
  assign pop_cmd_o   = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ----- sv/bis_back.sv -----
// bis_back: banked image memory, channel sequencer and two-step bilinear blend
// depends on bis_pkg; takes commands from bis_fifo, drives the result stream

module bis_back import bis_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pop_valid_i,
  input  bis_cmd_t            pop_cmd_i,
  output logic                pop_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // sample_value
  output logic [SampleW-1:0]  m_axis_tdata,
  // channel_index, inside_res
  output logic [OutUserW-1:0] m_axis_tuser,
  output logic                m_axis_tlast
);

  typedef struct packed {
    logic [ChanW-1:0]    chan;
    logic                last;
    logic                in_img;
    logic [FracBits-1:0] fx;
    logic [FracBits-1:0] fy;
    logic                tp;
    logic                lp;
  } bis_rd_t;

  typedef struct packed {
    logic [ChanW-1:0]    chan;
    logic                last;
    logic                in_img;
    logic [FracBits-1:0] fy;
    logic [TvW-1:0]      tv;
    logic [TvW-1:0]      bv;
  } bis_mix_t;

  function automatic logic [AddrW-1:0] bank_addr(input logic [RowW-1:0] row,
                                                 input logic [ColW-1:0] col,
                                                 input logic [ChanW-1:0] chan);
    logic [AddrW-1:0] pos;
    pos = AddrW'(row >> 1) * AddrW'(BankCols) + AddrW'(col >> 1);
    return pos * AddrW'(MaxChannels) + AddrW'(chan);
  endfunction

  logic             adv, is_wr, issue, at_last;
  logic [ChanW-1:0] cnt_q;
  logic [1:0]       wr_bank;
  logic [AddrW-1:0] wr_addr;
  logic [AddrW-1:0] rd_addr [NumBanks];
  logic [RowW-1:0]  bank_row [NumBanks];
  logic [ColW-1:0]  bank_col [NumBanks];
  logic [PixW-1:0]  rd_data [NumBanks];

  logic             s1_valid_q, s2_valid_q, m_valid_q;
  bis_rd_t          s1_q;
  bis_mix_t         s2_d, s2_q;
  logic [PixW-1:0]  tl, tr, bl, br;
  logic [WtW-1:0]   wx0, wy0;
  logic [ValW-1:0]  val_d;
  logic [SampleW-1:0]  out_val_q;
  logic [ChanW-1:0]    out_chan_q;
  logic                out_in_img_q, out_last_q;

  assign adv     = !m_valid_q || m_axis_tready;
  assign is_wr   = pop_valid_i && (pop_cmd_i.kind == KindWrite);
  assign issue   = pop_valid_i && (pop_cmd_i.kind == KindQuery) && adv;
  assign at_last = cnt_q == pop_cmd_i.chan;
  assign pop_o   = is_wr || (issue && at_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (issue) begin
      cnt_q <= at_last ? '0 : cnt_q + 1'b1;
    end
  end

  assign wr_bank = {pop_cmd_i.row[0], pop_cmd_i.col[0]};
  assign wr_addr = bank_addr(pop_cmd_i.row, pop_cmd_i.col, pop_cmd_i.chan);

  // each bank holds the anchor or its next row / column of matching parity
  always_comb begin
    for (int b = 0; b < NumBanks; b++) begin
      bank_row[b] = (pop_cmd_i.row[0] == b[1]) ? pop_cmd_i.row : pop_cmd_i.row + 1'b1;
      bank_col[b] = (pop_cmd_i.col[0] == b[0]) ? pop_cmd_i.col : pop_cmd_i.col + 1'b1;
      rd_addr[b]  = bank_addr(bank_row[b], bank_col[b], cnt_q);
    end
  end

  for (genvar gb = 0; gb < NumBanks; gb++) begin : g_bank
    logic [PixW-1:0] mem_q [BankDepth];
    logic [PixW-1:0] rd_q;

    always_ff @(posedge clk_i) begin
      if (is_wr && (wr_bank == 2'(gb))) begin
        mem_q[wr_addr] <= pop_cmd_i.value;
      end
      if (issue) begin
        rd_q <= mem_q[rd_addr[gb]];
      end
    end

    assign rd_data[gb] = rd_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q.chan   <= cnt_q;
      s1_q.last   <= at_last;
      s1_q.in_img <= pop_cmd_i.in_img;
      s1_q.fx     <= pop_cmd_i.fx;
      s1_q.fy     <= pop_cmd_i.fy;
      s1_q.tp     <= pop_cmd_i.row[0];
      s1_q.lp     <= pop_cmd_i.col[0];
      s2_q        <= s2_d;
      out_val_q   <= s2_q.in_img ? SampleW'(val_d) : '0;
      out_chan_q  <= s2_q.chan;
      out_in_img_q <= s2_q.in_img;
      out_last_q  <= s2_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= issue;
      s2_valid_q <= s1_valid_q;
      m_valid_q  <= s2_valid_q;
    end
  end

  // zero fraction means the far neighbour on that axis is taken from the near one
  always_comb begin
    tl = rd_data[{s1_q.tp, s1_q.lp}];
    tr = (s1_q.fx != '0) ? rd_data[{s1_q.tp, ~s1_q.lp}] : tl;
    bl = (s1_q.fy != '0) ? rd_data[{~s1_q.tp, s1_q.lp}] : tl;
    if (s1_q.fx == '0) begin
      br = bl;
    end else if (s1_q.fy == '0) begin
      br = tr;
    end else begin
      br = rd_data[{~s1_q.tp, ~s1_q.lp}];
    end
    wx0 = WtW'(One) - WtW'(s1_q.fx);
    s2_d.chan   = s1_q.chan;
    s2_d.last   = s1_q.last;
    s2_d.in_img = s1_q.in_img;
    s2_d.fy     = s1_q.fy;
    s2_d.tv     = TvW'(wx0) * TvW'(tl) + TvW'(s1_q.fx) * TvW'(tr);
    s2_d.bv     = TvW'(wx0) * TvW'(bl) + TvW'(s1_q.fx) * TvW'(br);
  end

  assign wy0   = WtW'(One) - WtW'(s2_q.fy);
  assign val_d = ValW'(wy0) * ValW'(s2_q.tv) + ValW'(s2_q.fy) * ValW'(s2_q.bv);

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_val_q;
  assign m_axis_tuser  = {out_in_img_q, out_chan_q};
  assign m_axis_tlast  = out_last_q;

endmodule

// ----- sv/bilinear_image_sampler.sv -----
// bilinear_image_sampler: top level; a query passes the queue, then the bank read and s1, s2
// and output registers; one result per cycle unless the output stalls, one per channel, set
// by the four parity banks of the image memory that deliver one channel's four neighbours
// each cycle. the input side takes an item every cycle while the four-entry queue has room.
// reset empties queue and pipeline and sets width 256, height 256, one channel; the image
// memory is not cleared. depends on bis_pkg and submodules

module bilinear_image_sampler import bis_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // pix_row, pix_col, pix_chan, pix_value, x_coord, y_coord, zero fill
  input  logic [InDataW-1:0]  s_axis_tdata,
  // kind
  input  logic [0:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // sample_value
  output logic [SampleW-1:0]  m_axis_tdata,
  // channel_index, inside_res
  output logic [OutUserW-1:0] m_axis_tuser,
  output logic                m_axis_tlast,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic     push, full, pop, pop_valid;
  bis_cmd_t push_cmd, pop_cmd;

  bis_front u_front (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .full_i     (full),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  bis_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .push_cmd_i  (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .pop_valid_o (pop_valid),
    .pop_cmd_o   (pop_cmd)
  );

  bis_back u_back (
    .clk_i,
    .rst_ni,
    .pop_valid_i (pop_valid),
    .pop_cmd_i   (pop_cmd),
    .pop_o       (pop),
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast
  );

endmodule

// ----- sv/bis_checker.sv -----
// bis_checker: port-level assertions on the result stream of the sampler
// depends on bis_pkg; attached to bilinear_image_sampler by the bind below

module bis_checker import bis_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [SampleW-1:0]  m_axis_tdata,
  input logic [OutUserW-1:0] m_axis_tuser,
  input logic                m_axis_tlast
);

  logic [ChanW-1:0] exp_chan_q;

  // channel expected on the next result of the current query
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_chan_q <= '0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      exp_chan_q <= m_axis_tlast ? '0 : m_axis_tuser[ChanW-1:0] + 1'b1;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_chan_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser[ChanW-1:0] == exp_chan_q)
    else $error("channel results out of sequence");

  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[ChanW] |-> m_axis_tdata == '0)
    else $error("outside result is not zero");

  a_top_chan_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[ChanW-1:0] == ChanW'(MaxChannels - 1)) |-> m_axis_tlast)
    else $error("highest channel result not marked last");

endmodule

bind bilinear_image_sampler bis_checker u_bis_checker (.*);
